[src/dual_servo_pwm_controller_defines.svh]
// assertion macros for the dual servo pwm controller
`ifndef DUAL_SERVO_PWM_CONTROLLER_DEFINES_SVH
`define DUAL_SERVO_PWM_CONTROLLER_DEFINES_SVH

// same-cycle property, sampled on clk_i, off while rst_ni is low
`define DSPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked in the cycle after its trigger
`define DSPC_ASSERT_NEXT(label, pre, post, msg) \
  `DSPC_ASSERT(label, (pre) |=> (post), msg)

`endif

[src/dspc_pkg.sv]
// types and constants of the dual servo pwm controller
`default_nettype none

package dspc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ANGLE = 2'd1,
    CMD_US    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PERIOD_TOP = 2'd0,
    REG_MIN_PULSE  = 2'd1,
    REG_MAX_PULSE  = 2'd2,
    REG_TICK_RATE  = 2'd3
  } reg_idx_e;

  localparam logic [15:0] NEUTRAL_PULSE   = 16'd1382;
  localparam logic [15:0] PERIOD_TOP_RST  = 16'd18431;
  localparam logic [15:0] MIN_PULSE_RST   = 16'd921;
  localparam logic [15:0] MAX_PULSE_RST   = 16'd1843;
  localparam logic [23:0] TICK_RATE_RST   = 24'd921600;

  localparam logic [7:0]  ANGLE_MAX = 8'd180;
  localparam logic [11:0] US_MIN    = 12'd500;
  localparam logic [11:0] US_MAX    = 12'd2500;

  // x/180 = (x>>2)/45, x>>2 below 2^22: exact with a 28 bit reciprocal shift
  localparam int unsigned ANG_PRESHIFT = 2;
  localparam int unsigned ANG_SHIFT    = 28;
  localparam logic [30:0] ANG_RECIP    = 31'd5965233;
  // x/10^6 = (x>>6)/15625, x>>6 below 2^30: exact with a 44 bit reciprocal shift
  localparam int unsigned US_PRESHIFT  = 6;
  localparam int unsigned US_SHIFT     = 44;
  localparam logic [30:0] US_RECIP     = 31'd1125899907;

  typedef struct packed {
    cmd_e        cmd;
    logic        channel;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        pwm_a;
    logic        pwm_b;
    logic        period_start;
    logic [15:0] active_pulse_a;
    logic [15:0] active_pulse_b;
  } out_item_t;

  typedef struct packed {
    reg_idx_e    index;
    logic [23:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

[src/dspc_in_if.sv]
// input item channel
`default_nettype none

interface dspc_in_if import dspc_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/dspc_out_if.sv]
// result item channel
`default_nettype none

interface dspc_out_if import dspc_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/dspc_cfg_if.sv]
// configuration write channel
`default_nettype none

interface dspc_cfg_if import dspc_pkg::*; ;
  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/dual_servo_pwm_controller.sv]
// Two-channel servo pwm generator with buffered compare values.
//
// in_i carries one item per handshake: a tick, an angle command or a
// microsecond command for channel A or B. Every item gives exactly one
// result on out_o: both pwm levels, the period start flag and the compare
// values in force. cfg_i writes the period top, the pulse limits and the
// tick rate; it is always ready.
// Throughput: one item per clock while out_o is not stalled. An item
// passes the input register, a multiply stage for the clamp and scale
// product, a reciprocal multiply stage for the constant divide, then the
// output register where counter and compare state update.
// The period counter loop is a compare and increment of cnt_q.
// Reset: counter 0, compare and pending values at the neutral pulse,
// registers at their defaults, all stages empty.
// A stalled receiver holds the output register; the stages behind it keep
// accepting until each holds an item, then in_i.ready drops.
`default_nettype none
`include "dual_servo_pwm_controller_defines.svh"

module dual_servo_pwm_controller import dspc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dspc_in_if.sink     in_i,
  dspc_out_if.source  out_o,
  dspc_cfg_if.sink    cfg_i
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef struct packed {
    cmd_e        cmd;
    logic        channel;
    logic [35:0] prod;
  } s2_t;

  typedef struct packed {
    cmd_e        cmd;
    logic        channel;
    logic [15:0] quot;
  } s3_t;

  // configuration
  logic [15:0] top_q, min_q, max_q;
  logic [23:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= PERIOD_TOP_RST;
      min_q  <= MIN_PULSE_RST;
      max_q  <= MAX_PULSE_RST;
      rate_q <= TICK_RATE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_PERIOD_TOP: top_q  <= cfg_i.data.data[15:0];
        REG_MIN_PULSE:  min_q  <= cfg_i.data.data[15:0];
        REG_MAX_PULSE:  max_q  <= cfg_i.data.data[15:0];
        REG_TICK_RATE:  rate_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // pipeline control
  logic v1_q, v2_q, v3_q, out_v_q;
  logic en_o, en3, en2, en1, go3;

  assign en_o = !out_v_q || out_o.ready;
  assign go3  = v3_q && en_o;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_o) out_v_q <= v3_q;
    end
  end

  // stage 1: clamp and scale product
  in_item_t    s1_q;
  logic [7:0]  ang_c;
  logic [11:0] us_c;
  logic        down_c;
  logic [15:0] diff_c;
  logic [11:0] mul_a_c;
  logic [23:0] mul_b_c;
  logic [35:0] prod1_c;

  always_comb begin
    ang_c = (s1_q.value > {8'd0, ANGLE_MAX}) ? ANGLE_MAX : s1_q.value[7:0];
    if (s1_q.value < {4'd0, US_MIN}) begin
      us_c = US_MIN;
    end else if (s1_q.value > {4'd0, US_MAX}) begin
      us_c = US_MAX;
    end else begin
      us_c = s1_q.value[11:0];
    end
    diff_c  = down_c ? (min_q - max_q) : (max_q - min_q);
    mul_a_c = (s1_q.cmd == CMD_ANGLE) ? {4'd0, ang_c} : us_c;
    mul_b_c = (s1_q.cmd == CMD_ANGLE) ? {8'd0, diff_c} : rate_q;
    prod1_c = {24'd0, mul_a_c} * {12'd0, mul_b_c};
  end

  // reversed limits map the angle downward from the minimum
  assign down_c = max_q < min_q;

  // stage 2: divide by a constant through a reciprocal
  s2_t         s2_q;
  logic [29:0] div_x_c;
  logic [30:0] div_k_c;
  logic [60:0] prod2_c;
  logic [16:0] quot_us_c;
  logic [15:0] quot_c;

  always_comb begin
    div_x_c = (s2_q.cmd == CMD_ANGLE) ? {8'd0, s2_q.prod[23:ANG_PRESHIFT]}
                                      : s2_q.prod[35:US_PRESHIFT];
    div_k_c = (s2_q.cmd == CMD_ANGLE) ? ANG_RECIP : US_RECIP;
    prod2_c = {31'd0, div_x_c} * {30'd0, div_k_c};
    quot_us_c = prod2_c[US_SHIFT +: 17];
    if (s2_q.cmd == CMD_ANGLE) begin
      quot_c = prod2_c[ANG_SHIFT +: 16];
    end else begin
      quot_c = quot_us_c[16] ? 16'hFFFF : quot_us_c[15:0];
    end
  end

  s3_t s3_q;

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= in_i.data;
    if (en2) s2_q <= '{cmd: s1_q.cmd, channel: s1_q.channel, prod: prod1_c};
    if (en3) s3_q <= '{cmd: s2_q.cmd, channel: s2_q.channel, quot: quot_c};
  end

  // final stage: counter and compare state, result formed
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [15:0] cmp_a_q, cmp_a_d, cmp_b_q, cmp_b_d;
  logic [15:0] pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  logic [15:0] pulse_c;
  logic        start_c;
  out_item_t   res_c, res_q;

  always_comb begin
    if (s3_q.cmd == CMD_ANGLE) begin
      pulse_c = down_c ? (min_q - s3_q.quot) : (min_q + s3_q.quot);
    end else begin
      pulse_c = s3_q.quot;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    cmp_a_d  = cmp_a_q;
    cmp_b_d  = cmp_b_q;
    pend_a_d = pend_a_q;
    pend_b_d = pend_b_q;
    start_c  = 1'b0;
    if (go3) begin
      case (s3_q.cmd)
        CMD_TICK: begin
          if (cnt_q == '0) begin
            cmp_a_d = pend_a_q;
            cmp_b_d = pend_b_q;
            start_c = 1'b1;
          end
          if (CMP_W'(cnt_q) >= CMP_W'(top_q)) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + COUNT_WIDTH'(1);
          end
        end
        CMD_ANGLE, CMD_US: begin
          if (s3_q.channel) begin
            pend_b_d = pulse_c;
          end else begin
            pend_a_d = pulse_c;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_c.pwm_a          = CMP_W'(cnt_q) <= CMP_W'(cmp_a_d);
    res_c.pwm_b          = CMP_W'(cnt_q) <= CMP_W'(cmp_b_d);
    res_c.period_start   = start_c;
    res_c.active_pulse_a = cmp_a_d;
    res_c.active_pulse_b = cmp_b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      cmp_a_q  <= NEUTRAL_PULSE;
      cmp_b_q  <= NEUTRAL_PULSE;
      pend_a_q <= NEUTRAL_PULSE;
      pend_b_q <= NEUTRAL_PULSE;
    end else begin
      cnt_q    <= cnt_d;
      cmp_a_q  <= cmp_a_d;
      cmp_b_q  <= cmp_b_d;
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go3) res_q <= res_c;
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = res_q;

  // checks
  `DSPC_ASSERT_NEXT(a_period_load, go3 && (s3_q.cmd == CMD_TICK) && (cnt_q == '0),
    (cmp_a_q == $past(pend_a_q)) && (cmp_b_q == $past(pend_b_q)),
    "compare values not loaded at period start")
  `DSPC_ASSERT_NEXT(a_count_hold, !(go3 && (s3_q.cmd == CMD_TICK)), $stable(cnt_q),
    "period counter moved without a tick")
  `DSPC_ASSERT(a_ready_full, !in_i.ready |-> (v1_q && v2_q && v3_q && out_v_q),
    "input stalled with an empty stage")

endmodule

`default_nettype wire
